@@ sv/ird_pkg.sv @@
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants for the integer to radix digits unit.
// ----------------------------------------------------------------------------
package ird_pkg;

  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;   // digit index into the 16-character alphabet
  localparam int ALPHA_MAX = 16;  // characters held in the digit registers
  localparam int LEN_W     = 5;
  localparam int WORD_W    = 64;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_ALPHA_LEN = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIGITS_LO = 2'd1;
  localparam logic [IDX_W-1:0] REG_DIGITS_HI = 2'd2;

  localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;
  localparam logic [LEN_W-1:0]  MIN_RADIX    = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SIGN,
    ST_DIV,
    ST_STORE,
    ST_RD,
    ST_PUT
  } ird_state_t;

  typedef struct packed {
    logic load;      // latch the incoming number
    logic div_init;  // clear remainder and bit count
    logic div_step;  // one restoring division step
    logic store;     // write digit, start next division, point read at newest digit
    logic out_sign;  // load '-' into the output register
    logic out_digit; // load the mapped digit into the output register
    logic rd_dec;    // step read pointer toward the least significant digit
  } ird_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic bit_last;
    logic mag_zero;
    logic rd_last;
    logic out_free;
  } ird_sts_t;

  function automatic logic [CHAR_W-1:0] alpha_char(
    input logic [2*WORD_W-1:0] words,
    input logic [DIGIT_W-1:0]  idx
  );
    return words[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

@@ sv/ird_alpha_chk.sv @@
// ----------------------------------------------------------------------------
// ird_alpha_chk
// Registered validity flag for the configured digit alphabet.
// ----------------------------------------------------------------------------
module ird_alpha_chk #(
  parameter int MAX_BASE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ird_pkg::LEN_W-1:0]           alpha_len,
  input  logic [2*ird_pkg::WORD_W-1:0]        alpha_words,
  output logic                                alpha_ok_r
);

  localparam int CAP_I = (MAX_BASE < ird_pkg::ALPHA_MAX) ? MAX_BASE : ird_pkg::ALPHA_MAX;
  localparam logic [ird_pkg::LEN_W-1:0] LEN_CAP = ird_pkg::LEN_W'(CAP_I);

  logic alpha_ok_nxt;

  always_comb begin
    logic [ird_pkg::ALPHA_MAX-1:0] used;
    logic [ird_pkg::CHAR_W-1:0]    ci;
    logic [ird_pkg::CHAR_W-1:0]    cj;
    logic                          bad;
    bad = 1'b0;
    for (int i = 0; i < ird_pkg::ALPHA_MAX; i++) begin
      used[i] = (ird_pkg::LEN_W'(i) < alpha_len);
    end
    for (int i = 0; i < ird_pkg::ALPHA_MAX; i++) begin
      ci = ird_pkg::alpha_char(alpha_words, ird_pkg::DIGIT_W'(i));
      if (used[i] && (ci == ird_pkg::CH_MINUS || ci == ird_pkg::CH_PLUS ||
                      ci <= ird_pkg::CH_SPACE || ci > ird_pkg::CH_TILDE)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < ird_pkg::ALPHA_MAX; j++) begin
        cj = ird_pkg::alpha_char(alpha_words, ird_pkg::DIGIT_W'(j));
        if (used[j] && ci == cj) begin
          bad = 1'b1;
        end
      end
    end
    alpha_ok_nxt = !bad && alpha_len >= ird_pkg::MIN_RADIX && alpha_len <= LEN_CAP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_ok_r <= 1'b0;
    end else begin
      alpha_ok_r <= alpha_ok_nxt;
    end
  end

endmodule

@@ sv/ird_ctrl.sv @@
// ----------------------------------------------------------------------------
// ird_ctrl
// Sequencer: sign, one digit division after another, then digit readout.
// ----------------------------------------------------------------------------
module ird_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ird_pkg::ird_sts_t sts,
  output ird_pkg::ird_cmd_t cmd
);

  ird_pkg::ird_state_t state_r;
  ird_pkg::ird_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ird_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ird_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ird_pkg::ST_CHECK;
        end
      end
      ird_pkg::ST_CHECK: begin
        cmd.div_init = 1'b1;
        if (!sts.alpha_ok) begin
          state_nxt = ird_pkg::ST_IDLE;
        end else if (sts.neg) begin
          state_nxt = ird_pkg::ST_SIGN;
        end else begin
          state_nxt = ird_pkg::ST_DIV;
        end
      end
      ird_pkg::ST_SIGN: begin
        if (sts.out_free) begin
          cmd.out_sign = 1'b1;
          state_nxt    = ird_pkg::ST_DIV;
        end
      end
      ird_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.bit_last) begin
          state_nxt = ird_pkg::ST_STORE;
        end
      end
      ird_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.mag_zero ? ird_pkg::ST_RD : ird_pkg::ST_DIV;
      end
      ird_pkg::ST_RD: begin
        // read data lands in the datapath's read register this cycle
        state_nxt = ird_pkg::ST_PUT;
      end
      ird_pkg::ST_PUT: begin
        if (sts.out_free) begin
          cmd.out_digit = 1'b1;
          if (sts.rd_last) begin
            state_nxt = ird_pkg::ST_IDLE;
          end else begin
            cmd.rd_dec = 1'b1;
            state_nxt  = ird_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ird_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ird_dpath.sv @@
// ----------------------------------------------------------------------------
// ird_dpath
// Magnitude register, bit-serial restoring divider, digit store and the
// output register.
// ----------------------------------------------------------------------------
module ird_dpath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ird_pkg::ird_cmd_t               cmd,
  output ird_pkg::ird_sts_t               sts,
  input  logic                            alpha_ok,
  input  logic [ird_pkg::LEN_W-1:0]       radix,
  input  logic [2*ird_pkg::WORD_W-1:0]    alpha_words,
  input  logic [VALUE_BITS-1:0]           number,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ird_pkg::CHAR_W-1:0]      out_char,
  output logic                            out_final
);

  localparam int AW  = $clog2(VALUE_BITS);
  localparam int NDW = $clog2(VALUE_BITS + 1);
  localparam logic [AW-1:0] BIT_LAST = AW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]          mag_r, mag_nxt;
  logic                           neg_r;
  logic [ird_pkg::DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [AW-1:0]                  bitcnt_r;
  logic [NDW-1:0]                 nd_r;
  logic [AW-1:0]                  rd_idx_r;
  logic [ird_pkg::DIGIT_W-1:0]    rd_data_r;
  logic [ird_pkg::DIGIT_W-1:0]    dig_mem [VALUE_BITS];
  logic                           out_valid_r, out_valid_nxt;
  logic [ird_pkg::CHAR_W-1:0]     out_char_r;
  logic                           out_final_r;
  logic [ird_pkg::LEN_W-1:0]      trial;
  logic                           ge;

  // shift next dividend bit into the partial remainder, subtract when it fits
  assign trial   = {rem_r, mag_r[VALUE_BITS-1]};
  assign ge      = trial >= radix;
  assign rem_nxt = ge ? ird_pkg::DIGIT_W'(trial - radix) : trial[ird_pkg::DIGIT_W-1:0];
  assign mag_nxt = {mag_r[VALUE_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= number[VALUE_BITS-1];
      mag_r <= number[VALUE_BITS-1] ? (VALUE_BITS'(0) - number) : number;
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
    end
    if (cmd.div_init || cmd.store) begin
      rem_r    <= '0;
      bitcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= rem_nxt;
      bitcnt_r <= bitcnt_r + AW'(1);
    end
    if (cmd.store) begin
      rd_idx_r <= nd_r[AW-1:0];
    end else if (cmd.rd_dec) begin
      rd_idx_r <= rd_idx_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r <= '0;
    end else if (cmd.load) begin
      nd_r <= '0;
    end else if (cmd.store) begin
      nd_r <= nd_r + NDW'(1);
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      dig_mem[nd_r[AW-1:0]] <= rem_r;
    end
    rd_data_r <= dig_mem[rd_idx_r];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_sign || cmd.out_digit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sign) begin
      out_char_r  <= ird_pkg::CH_MINUS;
      out_final_r <= 1'b0;
    end else if (cmd.out_digit) begin
      out_char_r  <= ird_pkg::alpha_char(alpha_words, rd_data_r);
      out_final_r <= (rd_idx_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_final  = out_final_r;

  assign sts.alpha_ok = alpha_ok;
  assign sts.neg      = neg_r;
  assign sts.bit_last = (bitcnt_r == BIT_LAST);
  assign sts.mag_zero = (mag_r == '0);
  assign sts.rd_last  = (rd_idx_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

@@ sv/integer_to_radix_digits_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Writes one signed number per request as text in a configured radix.
// ----------------------------------------------------------------------------
// One number is handled at a time. A negative number also puts out a '-'
// sign first, and the output can wait on out_tready. Each digit comes from
// a shared restoring divider that retires one quotient bit per cycle and
// then stores the digit. Each digit then takes one digit-store read and one
// output load. The output register lets the next character be prepared
// while the current one waits. An invalid alphabet drops the request in
// the check state with no output.
module integer_to_radix_digits_unit #(
  parameter int MAX_BASE   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    in_tdata,   // [VALUE_BITS-1:0] number
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ird_pkg::CHAR_W-1:0]         out_tdata,  // [7:0] character
  output logic                               out_tlast,  // final_char
  input  logic                               cfg_we,
  input  logic [ird_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ird_pkg::WORD_W-1:0]         cfg_wdata
);

  logic [ird_pkg::LEN_W-1:0]  alpha_len_r;
  logic [ird_pkg::WORD_W-1:0] digits_lo_r;
  logic [ird_pkg::WORD_W-1:0] digits_hi_r;
  logic                       alpha_ok;
  ird_pkg::ird_cmd_t          cmd;
  ird_pkg::ird_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_len_r <= '0;
      digits_lo_r <= '0;
      digits_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ird_pkg::REG_ALPHA_LEN: alpha_len_r <= cfg_wdata[ird_pkg::LEN_W-1:0];
        ird_pkg::REG_DIGITS_LO: digits_lo_r <= cfg_wdata;
        ird_pkg::REG_DIGITS_HI: digits_hi_r <= cfg_wdata;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  ird_alpha_chk #(
    .MAX_BASE (MAX_BASE)
  ) u_alpha_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .alpha_len   (alpha_len_r),
    .alpha_words ({digits_hi_r, digits_lo_r}),
    .alpha_ok_r  (alpha_ok)
  );

  ird_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ird_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .alpha_ok    (alpha_ok),
    .radix       (alpha_len_r),
    .alpha_words ({digits_hi_r, digits_lo_r}),
    .number      (in_tdata[VALUE_BITS-1:0]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_char    (out_tdata),
    .out_final   (out_tlast)
  );

endmodule

@@ sv/ird_chk.sv @@
// ----------------------------------------------------------------------------
// ird_chk
// Port-level checks for the integer to radix digits unit.
// ----------------------------------------------------------------------------
module ird_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ird_pkg::CHAR_W-1:0] out_tdata,
  input logic                       out_tlast
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output request changed while stalled");

  // one number at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous number in progress");

  // the sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == ird_pkg::CH_MINUS |-> !out_tlast)
    else $error("minus sign flagged as final character");

  // a pending character that is not the last keeps the input closed
  a_open_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input opened before the final character was loaded");

endmodule

bind integer_to_radix_digits_unit ird_chk u_ird_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
